// File: rtl/pat_pkg.sv
// Shared types, codes and helpers for the periodic alarm table.
`timescale 1ns / 1ps
package pat_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SELECT = 2'd2,
    CMD_CHECK  = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_FREE = 2'd3;

  localparam int MinPerHour  = 60;
  localparam int HoursPerDay = 24;
  localparam int MaxHour     = 23;
  localparam int MaxMinute   = 59;
  localparam int MaxAmount   = 99;

  // which result the datapath builds when the output register loads
  typedef enum logic [2:0] {
    RES_BAD  = 3'd0,
    RES_FULL = 3'd1,
    RES_ADD  = 3'd2,
    RES_DEL  = 3'd3,
    RES_SEL  = 3'd4,
    RES_CHK  = 3'd5
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     cnt_inc;
    logic     rd_scan;
    logic     rd_near;
    logic     out_load;
    res_sel_t res_sel;
  } ctl_t;

  typedef struct packed {
    logic add_bad;
    logic slot_free;
    logic cnt_last;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] period;
    logic [6:0] count;
  } entry_t;

  function automatic logic [10:0] minute_of_day(input logic [4:0] h, input logic [5:0] m);
    minute_of_day = 11'(h) * 11'(MinPerHour) + 11'(m);
  endfunction

  // sum below 128 reduced modulo 24
  function automatic logic [4:0] hour_wrap(input logic [6:0] s);
    logic [6:0] v;
    v = s;
    if (v >= 7'(4 * HoursPerDay)) v = v - 7'(4 * HoursPerDay);
    if (v >= 7'(2 * HoursPerDay)) v = v - 7'(2 * HoursPerDay);
    if (v >= 7'(HoursPerDay)) v = v - 7'(HoursPerDay);
    hour_wrap = 5'(v);
  endfunction

endpackage

// File: rtl/pat_ctrl.sv
// Command sequencer for the periodic alarm table.
`timescale 1ns / 1ps
module pat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        command,
  output logic              in_stall,
  input  pat_pkg::dp_stat_t stat,
  output pat_pkg::ctl_t     ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_DEL,
    S_SEL_SCAN,
    S_SEL_LAST,
    S_SEL_DONE,
    S_CHK_RD,
    S_CHK_DONE
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    ctl         = '0;
    ctl.res_sel = pat_pkg::RES_BAD;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          unique case (pat_pkg::cmd_t'(command))
            pat_pkg::CMD_ADD:    state_next = S_ADD;
            pat_pkg::CMD_DELETE: state_next = S_DEL;
            pat_pkg::CMD_SELECT: state_next = S_SEL_SCAN;
            pat_pkg::CMD_CHECK:  state_next = S_CHK_RD;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (stat.add_bad || stat.slot_free || stat.cnt_last) begin
          if (stat.add_bad) ctl.res_sel = pat_pkg::RES_BAD;
          else if (stat.slot_free) ctl.res_sel = pat_pkg::RES_ADD;
          else ctl.res_sel = pat_pkg::RES_FULL;
          if (stat.out_free) begin
            ctl.out_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          ctl.cnt_inc = 1'b1;
        end
      end
      S_DEL: begin
        ctl.res_sel = pat_pkg::RES_DEL;
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SEL_SCAN: begin
        ctl.rd_scan = 1'b1;
        ctl.cnt_inc = 1'b1;
        if (stat.cnt_last) state_next = S_SEL_LAST;
      end
      S_SEL_LAST: begin
        state_next = S_SEL_DONE;
      end
      S_SEL_DONE: begin
        ctl.res_sel = pat_pkg::RES_SEL;
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_CHK_RD: begin
        ctl.rd_near = 1'b1;
        state_next  = S_CHK_DONE;
      end
      S_CHK_DONE: begin
        ctl.res_sel = pat_pkg::RES_CHK;
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/pat_dp.sv
// Alarm storage, slot scan, match update and output register.
`timescale 1ns / 1ps
module pat_dp #(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        command,
  input  logic [4:0]        hour,
  input  logic [5:0]        minute,
  input  logic [6:0]        period_hours,
  input  logic [6:0]        dose_count,
  input  logic [3:0]        entry_index,
  input  pat_pkg::ctl_t     ctl,
  output pat_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic              matched,
  output logic [3:0]        slot,
  output logic              found
);

  localparam int IW = $clog2(ENTRIES);

  pat_pkg::entry_t mem [ENTRIES];
  pat_pkg::entry_t rd_data, wr_data;
  logic [IW-1:0]   rd_addr, wr_addr;
  logic            wr_en;

  logic [ENTRIES-1:0] valid, valid_next;
  logic [IW-1:0]      cnt, nearest, eval_idx, best, del_idx;
  logic               eval_en, any;
  logic [11:0]        best_key, key;
  logic [10:0]        now;

  logic [1:0] req_command;
  logic [4:0] req_hour;
  logic [5:0] req_minute;
  logic [6:0] req_period, req_count;
  logic [3:0] req_index;

  logic       out_free, del_ok, near_valid, near_match, take;
  logic [6:0] left;

  logic [1:0] status_next;
  logic       matched_next, found_next;
  logic [3:0] slot_next;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_command <= command;
      req_hour    <= hour;
      req_minute  <= minute;
      req_period  <= period_hours;
      req_count   <= dose_count;
      req_index   <= entry_index;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign del_idx  = IW'(req_index);
  assign del_ok   = (32'(req_index) < 32'(ENTRIES)) && valid[del_idx];
  assign now      = pat_pkg::minute_of_day(req_hour, req_minute);
  // negative differences wrap above every non-negative one
  assign key      = 12'(pat_pkg::minute_of_day(rd_data.hour, rd_data.minute)) - 12'(now);
  assign near_valid = valid[nearest];
  assign near_match = (rd_data.hour == req_hour) && (rd_data.minute == req_minute);
  assign left       = (rd_data.count == 7'd0) ? 7'd0 : rd_data.count - 7'd1;

  always_comb begin
    stat.add_bad = (req_hour > 5'(pat_pkg::MaxHour)) || (req_minute > 6'(pat_pkg::MaxMinute)) ||
                   (req_period == 7'd0) || (req_period > 7'(pat_pkg::MaxAmount)) ||
                   (req_count == 7'd0) || (req_count > 7'(pat_pkg::MaxAmount));
    stat.slot_free = !valid[cnt];
    stat.cnt_last  = (cnt == IW'(ENTRIES - 1));
    stat.out_free  = out_free;
  end

  // table memory
  assign rd_addr = ctl.rd_near ? nearest : cnt;
  assign take    = ctl.out_load && (req_command == 2'(pat_pkg::CMD_CHECK) ||
                                    req_command != 2'(pat_pkg::CMD_CHECK));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = '{hour: req_hour, minute: req_minute, period: req_period, count: req_count};
    if (take && ctl.res_sel == pat_pkg::RES_ADD) begin
      wr_en = 1'b1;
    end else if (take && ctl.res_sel == pat_pkg::RES_CHK && near_valid && near_match) begin
      wr_en   = 1'b1;
      wr_addr = nearest;
      wr_data = '{hour: pat_pkg::hour_wrap(7'(rd_data.hour) + rd_data.period),
                  minute: rd_data.minute, period: rd_data.period, count: left};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (ctl.rd_scan || ctl.rd_near) rd_data <= mem[rd_addr];
  end

  always_comb begin
    valid_next = valid;
    if (take) begin
      case (ctl.res_sel)
        pat_pkg::RES_ADD: valid_next[cnt] = 1'b1;
        pat_pkg::RES_DEL: if (del_ok) valid_next[del_idx] = 1'b0;
        pat_pkg::RES_CHK: if (near_valid && near_match && left == 7'd0) valid_next[nearest] = 1'b0;
        default: valid_next = valid;
      endcase
    end
  end

  // scan counter and nearest search
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      nearest  <= '0;
      cnt      <= '0;
      eval_en  <= 1'b0;
      any      <= 1'b0;
      best     <= '0;
      best_key <= '0;
      eval_idx <= '0;
    end else begin
      valid    <= valid_next;
      eval_en  <= ctl.rd_scan;
      eval_idx <= cnt;
      if (ctl.capture) begin
        cnt <= '0;
        any <= 1'b0;
      end else if (ctl.cnt_inc) begin
        cnt <= cnt + IW'(1);
      end
      if (eval_en && valid[eval_idx] && (!any || key < best_key)) begin
        any      <= 1'b1;
        best     <= eval_idx;
        best_key <= key;
      end
      if (take && ctl.res_sel == pat_pkg::RES_SEL && any) nearest <= best;
    end
  end

  // result
  always_comb begin
    status_next  = pat_pkg::ST_OK;
    matched_next = 1'b0;
    slot_next    = 4'd0;
    found_next   = 1'b0;
    case (ctl.res_sel)
      pat_pkg::RES_BAD:  status_next = pat_pkg::ST_BAD;
      pat_pkg::RES_FULL: status_next = pat_pkg::ST_FULL;
      pat_pkg::RES_ADD:  slot_next = 4'(cnt);
      pat_pkg::RES_DEL: begin
        status_next = del_ok ? pat_pkg::ST_OK : pat_pkg::ST_FREE;
        slot_next   = req_index;
      end
      pat_pkg::RES_SEL: begin
        slot_next  = any ? 4'(best) : 4'd0;
        found_next = any;
      end
      pat_pkg::RES_CHK: begin
        slot_next    = 4'(nearest);
        status_next  = near_valid ? pat_pkg::ST_OK : pat_pkg::ST_FREE;
        matched_next = near_valid && near_match;
      end
      default: status_next = pat_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status  <= status_next;
      matched <= matched_next;
      slot    <= slot_next;
      found   <= found_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> out_free) else $error("result loaded over a pending one");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (status == pat_pkg::ST_OK && !matched))
    else $error("found with bad status");

  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && matched) |-> (status == pat_pkg::ST_OK && !found))
    else $error("matched with bad status");

  a_add_sets: assert property (@(posedge clk) disable iff (rst)
    (ctl.out_load && ctl.res_sel == pat_pkg::RES_ADD) |=> valid[$past(cnt)])
    else $error("added slot not marked valid");

endmodule

// File: rtl/periodic_alarm_table.sv
// Periodic alarm table: top level.
//
// One request channel (in_valid / in_stall) carries command, hour, minute,
// period_hours, dose_count and entry_index; one result channel
// (out_valid / out_stall) returns status, matched, slot and found, one result
// per request. A request is taken when valid is high and stall is low.
// Requests are handled one at a time; in_stall is high while one is in work.
// Steps from request to result loaded in the output register:
//   add     one table slot checked per cycle for a free one
//   delete  valid bit cleared as the result loads
//   select  one slot read from the table memory per cycle
//   check   memory read, then compare and write back
// The next request can be taken in the cycle after the result loads.
// A stalled result holds in the output register; the next request may be
// taken and worked on, and waits at its end until the register is free.
// Reset empties the table and sets the selected slot to zero.
`timescale 1ns / 1ps
module periodic_alarm_table #(
  parameter int ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [4:0] hour,
  input  logic [5:0] minute,
  input  logic [6:0] period_hours,
  input  logic [6:0] dose_count,
  input  logic [3:0] entry_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic       matched,
  output logic [3:0] slot,
  output logic       found
);

  pat_pkg::ctl_t     ctl;
  pat_pkg::dp_stat_t stat;

  pat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  pat_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .command      (command),
    .hour         (hour),
    .minute       (minute),
    .period_hours (period_hours),
    .dose_count   (dose_count),
    .entry_index  (entry_index),
    .ctl          (ctl),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .matched      (matched),
    .slot         (slot),
    .found        (found)
  );

endmodule

// File: tb/sv/tb_periodic_alarm_table.sv
// Testbench for the periodic alarm table: directed request table, then random requests.
`timescale 1ns / 1ps
module tb_periodic_alarm_table;

  localparam int NumEntries  = 16;
  localparam int NumRequests = 550;
  localparam int PastBias    = 4096;

  typedef struct {
    pat_pkg::cmd_t cmd;
    logic [4:0]    hour;
    logic [5:0]    minute;
    logic [6:0]    period;
    logic [6:0]    count;
    logic [3:0]    index;
  } alarm_req_t;

  typedef struct {
    logic [1:0] status;
    logic       matched;
    logic [3:0] slot;
    logic       found;
  } alarm_res_t;

  typedef struct {
    alarm_req_t req;
    bit         known;
    alarm_res_t res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] command = pat_pkg::CMD_ADD;
  logic [4:0] hour = '0;
  logic [5:0] minute = '0;
  logic [6:0] period_hours = '0;
  logic [6:0] dose_count = '0;
  logic [3:0] entry_index = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  logic       matched;
  logic [3:0] slot;
  logic       found;

  // model of the alarm table
  logic [4:0] al_hour[NumEntries];
  logic [5:0] al_minute[NumEntries];
  logic [6:0] al_period[NumEntries];
  logic [6:0] al_left[NumEntries];
  bit         al_used[NumEntries];
  int         sel_slot = 0;

  alarm_res_t pending[$];
  dir_row_t   dir_rows[$];
  int         n_err = 0;
  int         n_sent = 0;
  int         idle_pct = 14;
  int         stall_pct = 85;

  periodic_alarm_table #(.ENTRIES(NumEntries)) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .hour(hour),
    .minute(minute),
    .period_hours(period_hours),
    .dose_count(dose_count),
    .entry_index(entry_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .matched(matched),
    .slot(slot),
    .found(found)
  );

  always #5 clk = ~clk;

  function automatic alarm_res_t alarm_apply(alarm_req_t r);
    alarm_res_t res;
    int now, at, key, best_key, best, s;
    bit any;
    res = '{pat_pkg::ST_OK, 1'b0, 4'd0, 1'b0};
    any = 1'b0;
    best = 0;
    best_key = 0;
    case (r.cmd)
      pat_pkg::CMD_ADD: begin
        if (r.hour > pat_pkg::MaxHour || r.minute > pat_pkg::MaxMinute || r.period == 0 ||
            r.period > pat_pkg::MaxAmount || r.count == 0 ||
            r.count > pat_pkg::MaxAmount) begin
          res.status = pat_pkg::ST_BAD;
        end else begin
          res.status = pat_pkg::ST_FULL;
          for (int i = 0; i < NumEntries; i++) begin
            if (!any && !al_used[i]) begin
              al_hour[i] = r.hour;
              al_minute[i] = r.minute;
              al_period[i] = r.period;
              al_left[i] = r.count;
              al_used[i] = 1'b1;
              any = 1'b1;
              res.status = pat_pkg::ST_OK;
              res.slot = 4'(i);
            end
          end
        end
      end
      pat_pkg::CMD_DELETE: begin
        res.slot = r.index;
        if (al_used[r.index]) al_used[r.index] = 1'b0;
        else res.status = pat_pkg::ST_FREE;
      end
      pat_pkg::CMD_SELECT: begin
        now = int'(r.hour) * pat_pkg::MinPerHour + int'(r.minute);
        for (int i = 0; i < NumEntries; i++) begin
          if (al_used[i]) begin
            at = int'(al_hour[i]) * pat_pkg::MinPerHour + int'(al_minute[i]);
            key = at - now;
            // past alarms rank after every future one
            if (key < 0) key += PastBias;
            if (!any || key < best_key) begin
              best_key = key;
              best = i;
              any = 1'b1;
            end
          end
        end
        if (any) begin
          sel_slot = best;
          res.slot = 4'(best);
          res.found = 1'b1;
        end
      end
      default: begin
        s = sel_slot;
        res.slot = 4'(s);
        if (!al_used[s]) begin
          res.status = pat_pkg::ST_FREE;
        end else if (al_hour[s] == r.hour && al_minute[s] == r.minute) begin
          res.matched = 1'b1;
          al_left[s] = (al_left[s] != 0) ? al_left[s] - 7'd1 : 7'd0;
          al_hour[s] = 5'((int'(al_hour[s]) + int'(al_period[s])) % pat_pkg::HoursPerDay);
          if (al_left[s] == 0) al_used[s] = 1'b0;
        end
      end
    endcase
    return res;
  endfunction

  function automatic void add_row(pat_pkg::cmd_t c, int h, int m, int p, int n, int x,
                                  bit known = 1'b0, int st = 0, int sl = 0);
    dir_row_t row;
    row.req = '{c, 5'(h), 6'(m), 7'(p), 7'(n), 4'(x)};
    row.known = known;
    row.res = '{2'(st), 1'b0, 4'(sl), 1'b0};
    dir_rows.push_back(row);
  endfunction

  function automatic alarm_req_t noise_req(pat_pkg::cmd_t c);
    alarm_req_t r;
    r.cmd = c;
    r.hour = 5'($urandom);
    r.minute = 6'($urandom);
    r.period = 7'($urandom);
    r.count = 7'($urandom);
    r.index = 4'($urandom);
    return r;
  endfunction

  function automatic int pick_used();
    int idx[$];
    for (int i = 0; i < NumEntries; i++) if (al_used[i]) idx.push_back(i);
    if (idx.size() == 0) return -1;
    return idx[$urandom_range(idx.size() - 1)];
  endfunction

  task automatic offer(alarm_req_t r, bit known, alarm_res_t want);
    alarm_res_t got;
    case (n_sent * 3 / NumRequests)
      0: begin
        idle_pct = 14;
        stall_pct = 85;
      end
      1: begin
        idle_pct = 85;
        stall_pct = 14;
      end
      default: begin
        idle_pct = 0;
        stall_pct = 0;
      end
    endcase
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= r.cmd;
    hour <= r.hour;
    minute <= r.minute;
    period_hours <= r.period;
    dose_count <= r.count;
    entry_index <= r.index;
    do @(posedge clk); while (in_stall);
    got = alarm_apply(r);
    pending.push_back(known ? want : got);
    n_sent++;
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    alarm_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        n_err++;
      end else begin
        want = pending.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          n_err++;
        end
        if (matched !== want.matched) begin
          $error("matched: expected %0d, got %0d", want.matched, matched);
          n_err++;
        end
        if (slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, slot);
          n_err++;
        end
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          n_err++;
        end
      end
    end
  end

  initial begin
    alarm_req_t r;
    alarm_res_t none;
    int s, pick, add_pct, guard;
    none = '{pat_pkg::ST_OK, 1'b0, 4'd0, 1'b0};

    add_row(pat_pkg::CMD_CHECK, 0, 0, 0, 0, 0, 1, pat_pkg::ST_FREE, 0);
    add_row(pat_pkg::CMD_SELECT, 12, 30, 0, 0, 0, 1, pat_pkg::ST_OK, 0);
    add_row(pat_pkg::CMD_DELETE, 0, 0, 0, 0, 15, 1, pat_pkg::ST_FREE, 15);
    add_row(pat_pkg::CMD_ADD, 24, 0, 1, 1, 0, 1, pat_pkg::ST_BAD, 0);
    add_row(pat_pkg::CMD_ADD, 0, 60, 1, 1, 0, 1, pat_pkg::ST_BAD, 0);
    add_row(pat_pkg::CMD_ADD, 0, 0, 0, 1, 0, 1, pat_pkg::ST_BAD, 0);
    add_row(pat_pkg::CMD_ADD, 0, 0, 100, 1, 0, 1, pat_pkg::ST_BAD, 0);
    add_row(pat_pkg::CMD_ADD, 0, 0, 1, 0, 0, 1, pat_pkg::ST_BAD, 0);
    add_row(pat_pkg::CMD_ADD, 0, 0, 1, 100, 0, 1, pat_pkg::ST_BAD, 0);
    add_row(pat_pkg::CMD_ADD, 31, 63, 127, 127, 15, 1, pat_pkg::ST_BAD, 0);
    add_row(pat_pkg::CMD_ADD, 0, 0, 1, 1, 0, 1, pat_pkg::ST_OK, 0);
    add_row(pat_pkg::CMD_ADD, 23, 59, 99, 99, 0, 1, pat_pkg::ST_OK, 1);
    add_row(pat_pkg::CMD_ADD, 12, 0, 50, 2, 0, 1, pat_pkg::ST_OK, 2);
    add_row(pat_pkg::CMD_SELECT, 0, 0, 0, 0, 0);
    add_row(pat_pkg::CMD_CHECK, 0, 0, 0, 0, 0);
    add_row(pat_pkg::CMD_CHECK, 0, 0, 0, 0, 0);
    add_row(pat_pkg::CMD_SELECT, 31, 63, 127, 127, 15);
    add_row(pat_pkg::CMD_SELECT, 23, 59, 0, 0, 0);
    add_row(pat_pkg::CMD_CHECK, 23, 59, 0, 0, 0);
    add_row(pat_pkg::CMD_CHECK, 2, 59, 0, 0, 0);
    add_row(pat_pkg::CMD_CHECK, 5, 0, 0, 0, 0);
    add_row(pat_pkg::CMD_DELETE, 0, 0, 0, 0, 1, 1, pat_pkg::ST_OK, 1);
    add_row(pat_pkg::CMD_DELETE, 0, 0, 0, 0, 1, 1, pat_pkg::ST_FREE, 1);
    add_row(pat_pkg::CMD_ADD, 6, 15, 24, 3, 0, 1, pat_pkg::ST_OK, 0);
    add_row(pat_pkg::CMD_DELETE, 0, 0, 0, 0, 0, 1, pat_pkg::ST_OK, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) offer(dir_rows[i].req, dir_rows[i].known, dir_rows[i].res);

    while (n_sent < NumRequests) begin
      // add bursts fill the table so the full case is reached
      add_pct = ((n_sent / 20) % 3 == 0) ? 70 : 20;
      pick = $urandom_range(99);
      if (pick < add_pct) begin
        r = noise_req(pat_pkg::CMD_ADD);
        if ($urandom_range(9) != 0) begin
          r.hour = 5'($urandom_range(pat_pkg::MaxHour));
          r.minute = 6'($urandom_range(pat_pkg::MaxMinute));
          r.period = 7'($urandom_range(1, pat_pkg::MaxAmount));
          r.count = ($urandom_range(3) == 0) ? 7'($urandom_range(1, pat_pkg::MaxAmount))
                                             : 7'($urandom_range(1, 3));
        end
        offer(r, 1'b0, none);
      end else begin
        pick = $urandom_range(99);
        s = pick_used();
        if (pick < 20) begin
          r = noise_req(pat_pkg::CMD_DELETE);
          if (s >= 0 && $urandom_range(9) < 7) r.index = 4'(s);
          offer(r, 1'b0, none);
        end else if (pick < 60 && s >= 0) begin
          // select on a stored alarm's time, then check it
          r = noise_req(pat_pkg::CMD_SELECT);
          r.hour = al_hour[s];
          r.minute = al_minute[s];
          offer(r, 1'b0, none);
          r = noise_req(pat_pkg::CMD_CHECK);
          if ($urandom_range(4) != 0) begin
            r.hour = al_hour[s];
            r.minute = al_minute[s];
          end
          offer(r, 1'b0, none);
        end else if (pick < 80) begin
          r = noise_req(pat_pkg::CMD_SELECT);
          offer(r, 1'b0, none);
        end else begin
          r = noise_req(pat_pkg::CMD_CHECK);
          if (al_used[sel_slot] && $urandom_range(1) == 1) begin
            r.hour = al_hour[sel_slot];
            r.minute = al_minute[sel_slot];
          end
          offer(r, 1'b0, none);
        end
      end
    end

    in_valid <= 1'b0;
    guard = 0;
    while (pending.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4 * NumEntries) @(posedge clk);
    if (pending.size() != 0) begin
      $error("%0d results never arrived", pending.size());
      n_err++;
    end
    if (n_err == 0) $display("periodic_alarm_table test passed");
    else $display("periodic_alarm_table test failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("periodic_alarm_table test failed");
    $finish;
  end

endmodule
